[rtl/rsb_pkg.sv]
// ----------------------------------------------------------------------------
// Rotated sprite blitter package
// Register map, configuration bundle and action codes shared by the blitter
// top level and its register block.
// ----------------------------------------------------------------------------
package rsb_pkg;

	// Byte address width of the register port: eight 32-bit registers.
	localparam int PADDR_W = 5;

	// Width of the configuration angle registers as held inside the block.
	// The bus writes 16 bits and sign-extends them; the extra bits carry the
	// reset value of one (1 << FRAC_BITS) for fraction widths up to 16.
	localparam int ANGLE_W = 18;

	// Register index (byte address / 4).
	typedef enum logic [2:0] {
		REG_COS_ANGLE     = 3'd0,
		REG_SIN_ANGLE     = 3'd1,
		REG_SPRITE_WIDTH  = 3'd2,
		REG_SPRITE_HEIGHT = 3'd3,
		REG_KEY_COLOR     = 3'd4,
		REG_ORIGIN_X      = 3'd5,
		REG_ORIGIN_Y      = 3'd6,
		REG_DRAWING_ON    = 3'd7
	} reg_idx_t;

	// Input item action codes.
	localparam logic ACTION_LOAD   = 1'b0;
	localparam logic ACTION_RENDER = 1'b1;

	// Reset size of the sprite in both directions.
	localparam logic [6:0] RST_SPRITE_SIZE = 7'd64;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] cos_angle;
		logic signed [ANGLE_W-1:0] sin_angle;
		logic        [6:0]         sprite_width;
		logic        [6:0]         sprite_height;
		logic        [31:0]        key_color;
		logic signed [11:0]        origin_x;
		logic signed [11:0]        origin_y;
		logic                      drawing_on;
	} cfg_t;

endpackage

[rtl/rsb_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle when enabled: a write, or a read whose data is
// registered and held until the next enabled read.
// ----------------------------------------------------------------------------
module rsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

[rtl/rsb_csr.sv]
// ----------------------------------------------------------------------------
// Rotated sprite blitter register block
// APB-style register port with zero wait states; holds the rotation,
// sprite size, color key, screen origin and drawing enable, and reads them back.
// ----------------------------------------------------------------------------
module rsb_csr #(
	parameter int FRAC_BITS = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rsb_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output rsb_pkg::cfg_t               cfg
);

	rsb_pkg::cfg_t     cfg_q;
	rsb_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = rsb_pkg::reg_idx_t'(paddr[rsb_pkg::PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_angle     <= rsb_pkg::ANGLE_W'(1 << FRAC_BITS);
			cfg_q.sin_angle     <= '0;
			cfg_q.sprite_width  <= rsb_pkg::RST_SPRITE_SIZE;
			cfg_q.sprite_height <= rsb_pkg::RST_SPRITE_SIZE;
			cfg_q.key_color     <= '0;
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.drawing_on    <= 1'b1;
		end else if (wr_en) begin
			unique case (idx)
				rsb_pkg::REG_COS_ANGLE: begin
					cfg_q.cos_angle <= rsb_pkg::ANGLE_W'($signed(pwdata[15:0]));
				end
				rsb_pkg::REG_SIN_ANGLE: begin
					cfg_q.sin_angle <= rsb_pkg::ANGLE_W'($signed(pwdata[15:0]));
				end
				rsb_pkg::REG_SPRITE_WIDTH:  cfg_q.sprite_width  <= pwdata[6:0];
				rsb_pkg::REG_SPRITE_HEIGHT: cfg_q.sprite_height <= pwdata[6:0];
				rsb_pkg::REG_KEY_COLOR:     cfg_q.key_color     <= pwdata;
				rsb_pkg::REG_ORIGIN_X:      cfg_q.origin_x      <= $signed(pwdata[11:0]);
				rsb_pkg::REG_ORIGIN_Y:      cfg_q.origin_y      <= $signed(pwdata[11:0]);
				rsb_pkg::REG_DRAWING_ON:    cfg_q.drawing_on    <= pwdata[0];
			endcase
		end
	end

	// Read back signed registers sign-extended.
	always_comb begin
		prdata = '0;
		unique case (idx)
			rsb_pkg::REG_COS_ANGLE:     prdata = 32'(cfg_q.cos_angle);
			rsb_pkg::REG_SIN_ANGLE:     prdata = 32'(cfg_q.sin_angle);
			rsb_pkg::REG_SPRITE_WIDTH:  prdata = 32'(cfg_q.sprite_width);
			rsb_pkg::REG_SPRITE_HEIGHT: prdata = 32'(cfg_q.sprite_height);
			rsb_pkg::REG_KEY_COLOR:     prdata = cfg_q.key_color;
			rsb_pkg::REG_ORIGIN_X:      prdata = 32'(cfg_q.origin_x);
			rsb_pkg::REG_ORIGIN_Y:      prdata = 32'(cfg_q.origin_y);
			rsb_pkg::REG_DRAWING_ON:    prdata = 32'(cfg_q.drawing_on);
		endcase
	end

endmodule

[rtl/rotated_sprite_blit.sv]
// ----------------------------------------------------------------------------
// Rotated sprite blitter with color key
// Five-stage pipeline that writes sprite pixels into a store and renders
// destination offsets through an inverse rotation into that store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transaction per item. action LOAD
//   writes load_color at load_index of the sprite store; action RENDER maps
//   (offset_x, offset_y) back into sprite space and looks up the color there.
//   Output channel (out_valid/out_ready): one transaction per rendered pixel
//   whose source lies inside the sprite and whose color differs from the key,
//   while drawing_on is set; loads and rejected renders produce no transaction.
//   Throughput: one item per clock unless a held result stalls the pipeline.
//   An emitted pixel is presented on out_valid from the store access stage.
//   Stages: multiply, sum, truncate and bound, address, store access.
//   The store sees one access per cycle at a single stage, so loads and
//   renders take effect in input order.
//   Stall: every stage holds while the stage after it is full and stalled;
//   bubbles and dropped items are squeezed out, so in_ready stays high while
//   a result waits as long as some stage ahead is empty.
//   Reset: arst_n clears all stage valid bits and loads the register reset
//   values; the sprite store keeps no reset and must be loaded before render.
//   Registers are to be written only while the pipeline is empty; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module rotated_sprite_blit #(
	parameter int MAX_SIZE   = 64,
	parameter int COLOR_BITS = 32,
	parameter int FRAC_BITS  = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rsb_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic [11:0]                 load_index,
	input  logic [31:0]                 load_color,
	input  logic signed [6:0]           offset_x,
	input  logic signed [6:0]           offset_y,
	// output channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [12:0]          plot_x,
	output logic signed [12:0]          plot_y,
	output logic [31:0]                 color
);

	localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);
	// offset times angle, then the sum of two products plus half the size
	localparam int PROD_W = 7 + rsb_pkg::ANGLE_W;
	localparam int SUM_W  = PROD_W + 2;
	// integer part after dropping the fraction
	localparam int TW     = SUM_W - FRAC_BITS;
	localparam int CW     = (TW - 1 > 7) ? TW - 1 : 7;
	// flat address before the store bound check
	localparam int AFW    = (ADDR_W + 1 > 15) ? ADDR_W + 1 : 15;
	localparam logic signed [SUM_W-1:0] RND = SUM_W'((1 << FRAC_BITS) - 1);

	rsb_pkg::cfg_t cfg;

	rsb_csr #(
		.FRAC_BITS(FRAC_BITS)
	) u_csr (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Stage advance chain: a stage loads when it is empty or its item moves on.
	logic adv1, adv2, adv3, adv4, adv5;
	logic emit5;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	assign adv5     = !emit5 || out_ready;
	assign adv4     = !v_s4 || adv5;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: rotation products, screen point ----------------
	logic signed [PROD_W-1:0] dx_e, dy_e, cos_e, sin_e;
	logic signed [PROD_W-1:0] pxc_s1, pys_s1, pyc_s1, pxs_s1;
	logic                     rend_s1;
	logic [11:0]              idx_s1;
	logic [COLOR_BITS-1:0]    col_s1;
	logic signed [12:0]       plx_s1, ply_s1;

	assign dx_e  = PROD_W'(offset_x);
	assign dy_e  = PROD_W'(offset_y);
	assign cos_e = PROD_W'(cfg.cos_angle);
	assign sin_e = PROD_W'(cfg.sin_angle);

	always_ff @(posedge clk) begin
		if (adv1) begin
			rend_s1 <= (action == rsb_pkg::ACTION_RENDER);
			idx_s1  <= load_index;
			col_s1  <= load_color[COLOR_BITS-1:0];
			pxc_s1  <= dx_e * cos_e;
			pys_s1  <= dy_e * sin_e;
			pyc_s1  <= dy_e * cos_e;
			pxs_s1  <= dx_e * sin_e;
			plx_s1  <= 13'(cfg.origin_x) + 13'(offset_x);
			ply_s1  <= 13'(cfg.origin_y) + 13'(offset_y);
		end
	end

	// ---------------- stage 2: rotated position plus sprite center ----------------
	logic signed [SUM_W-1:0] bias_x, bias_y;
	logic signed [SUM_W-1:0] nx_s2, ny_s2;
	logic                    rend_s2;
	logic [11:0]             idx_s2;
	logic [COLOR_BITS-1:0]   col_s2;
	logic signed [12:0]      plx_s2, ply_s2;

	assign bias_x = $signed(SUM_W'(cfg.sprite_width[6:1]) << FRAC_BITS);
	assign bias_y = $signed(SUM_W'(cfg.sprite_height[6:1]) << FRAC_BITS);

	always_ff @(posedge clk) begin
		if (adv2) begin
			rend_s2 <= rend_s1;
			idx_s2  <= idx_s1;
			col_s2  <= col_s1;
			nx_s2   <= SUM_W'(pxc_s1) + SUM_W'(pys_s1) + bias_x;
			ny_s2   <= SUM_W'(pyc_s1) - SUM_W'(pxs_s1) + bias_y;
			plx_s2  <= plx_s1;
			ply_s2  <= ply_s1;
		end
	end

	// ---------------- stage 3: truncate toward zero, bound against sprite ----------------
	logic signed [SUM_W-1:0] nx_adj, ny_adj;
	logic [TW-1:0]           tx_full, ty_full;
	logic                    in_x, in_y;
	logic                    rend_s3, ok_s3;
	logic [11:0]             idx_s3;
	logic [COLOR_BITS-1:0]   col_s3;
	logic [6:0]              tx_s3, ty_s3;
	logic signed [12:0]      plx_s3, ply_s3;

	// Round a negative value up before the shift to truncate toward zero.
	assign nx_adj  = nx_s2 + (nx_s2[SUM_W-1] ? RND : '0);
	assign ny_adj  = ny_s2 + (ny_s2[SUM_W-1] ? RND : '0);
	assign tx_full = nx_adj[SUM_W-1:FRAC_BITS];
	assign ty_full = ny_adj[SUM_W-1:FRAC_BITS];
	assign in_x    = !tx_full[TW-1] && (CW'(tx_full[TW-2:0]) < CW'(cfg.sprite_width));
	assign in_y    = !ty_full[TW-1] && (CW'(ty_full[TW-2:0]) < CW'(cfg.sprite_height));

	always_ff @(posedge clk) begin
		if (adv3) begin
			rend_s3 <= rend_s2;
			// loads pass here; their address is bounded in the next stage
			ok_s3   <= !rend_s2 || (cfg.drawing_on && in_x && in_y);
			idx_s3  <= idx_s2;
			col_s3  <= col_s2;
			tx_s3   <= tx_full[6:0];
			ty_s3   <= ty_full[6:0];
			plx_s3  <= plx_s2;
			ply_s3  <= ply_s2;
		end
	end

	// ---------------- stage 4: flat store address, store bound ----------------
	logic [AFW-1:0]        addr_full;
	logic                  rend_s4, ok_s4;
	logic [ADDR_W-1:0]     addr_s4;
	logic [COLOR_BITS-1:0] col_s4;
	logic signed [12:0]    plx_s4, ply_s4;

	assign addr_full = rend_s3
		? AFW'(AFW'(ty_s3) * AFW'(cfg.sprite_width) + AFW'(tx_s3))
		: AFW'(idx_s3);

	always_ff @(posedge clk) begin
		if (adv4) begin
			rend_s4 <= rend_s3;
			ok_s4   <= ok_s3 && (addr_full < AFW'(DEPTH));
			addr_s4 <= addr_full[ADDR_W-1:0];
			col_s4  <= col_s3;
			plx_s4  <= plx_s3;
			ply_s4  <= ply_s3;
		end
	end

	// ---------------- stage 5: store access, color key, result ----------------
	// Write a load or read for a render that passed its checks as the item moves
	// into the last stage; the read data then holds with it while the receiver stalls.
	logic                  ram_en;
	logic [COLOR_BITS-1:0] rdata;
	logic                  rend_s5, ok_s5;
	logic signed [12:0]    plx_s5, ply_s5;

	assign ram_en = v_s4 && adv5 && ok_s4;

	rsb_ram #(
		.WIDTH(COLOR_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.en   (ram_en),
		.we   (!rend_s4),
		.addr (addr_s4),
		.wdata(col_s4),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (adv5) begin
			rend_s5 <= rend_s4;
			ok_s5   <= ok_s4;
			plx_s5  <= plx_s4;
			ply_s5  <= ply_s4;
		end
	end

	// Drop loads, rejected renders and keyed pixels without a transaction.
	assign emit5     = v_s5 && rend_s5 && ok_s5 && (rdata != cfg.key_color[COLOR_BITS-1:0]);
	assign out_valid = emit5;
	assign plot_x    = plx_s5;
	assign plot_y    = ply_s5;
	assign color     = 32'(rdata);

endmodule
